// ----- rtl/core/ladrc_pkg.sv -----
package ladrc_pkg;

  localparam logic [31:0] DEF_STEP = 32'd858993;
  localparam logic signed [30:0] DEF_GAIN = 31'sd10000;
  localparam logic [19:0] DEF_WC = 20'd800;
  localparam logic [19:0] DEF_WO = 20'd2400;
  localparam logic [31:0] VBOUND_K = 32'd2355715498;

  localparam logic [2:0] REG_STEP = 3'd0;
  localparam logic [2:0] REG_GAIN = 3'd1;
  localparam logic [2:0] REG_WC = 3'd2;
  localparam logic [2:0] REG_WO = 3'd3;
  localparam logic [2:0] REG_UPPER = 3'd4;
  localparam logic [2:0] REG_LOWER = 3'd5;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  // Datapath operations, one per controller step.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ERR,
    OP_FF,
    OP_T1,
    OP_Z1,
    OP_Q,
    OP_E2,
    OP_Z2,
    OP_T2,
    OP_DIV,
    OP_BOUND,
    OP_CLAMP
  } op_t;

  typedef struct packed {
    op_t op;
    logic start;
  } cmd_t;

  typedef struct packed {
    logic busy;
  } sts_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > 65'sd0 && s[64] != s[63]) return S64_MAX;
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] mag(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic signed [63:0] from_mag(input logic neg, input logic [63:0] m);
    if (neg) return m[63] ? S64_MIN : 64'(-$signed(m));
    return m[63] ? S64_MAX : $signed(m);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

endpackage

// ----- rtl/core/ladrc_mul.sv -----
// Sequential 64x64 unsigned multiplier, one 32x32 partial product a cycle.
module ladrc_mul import ladrc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] prod
);
  logic [2:0] cnt_r, cnt_nxt;
  logic [63:0] a_r, b_r;
  logic [127:0] acc_r, acc_nxt;
  logic [63:0] pp_r;
  logic [31:0] xa, xb;
  logic [1:0] idx;

  assign idx = cnt_r[1:0] - 2'd1;
  always_comb begin
    xa = idx[0] ? a_r[63:32] : a_r[31:0];
    xb = idx[1] ? b_r[63:32] : b_r[31:0];
  end

  always_comb begin
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    if (start) begin
      cnt_nxt = 3'd1;
      acc_nxt = '0;
    end else if (cnt_r != 3'd0) begin
      cnt_nxt = (cnt_r == 3'd5) ? 3'd0 : cnt_r + 3'd1;
      if (cnt_r >= 3'd2) begin
        unique case (cnt_r)
          3'd2: acc_nxt = acc_r + {64'd0, pp_r};
          3'd3: acc_nxt = acc_r + {32'd0, pp_r, 32'd0};
          3'd4: acc_nxt = acc_r + {32'd0, pp_r, 32'd0};
          default: acc_nxt = acc_r + {pp_r, 64'd0};
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    pp_r <= xa * xb;
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
  end

  assign done = (cnt_r == 3'd5);
  assign prod = acc_nxt;
endmodule

// ----- rtl/core/ladrc_div.sv -----
// Restoring divider, one quotient bit a cycle.
module ladrc_div import ladrc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quo
);
  logic [6:0] cnt_r;
  logic [63:0] q_r, d_r;
  logic [64:0] rem_r, trial;

  assign trial = {rem_r[63:0], q_r[63]} - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= 7'd64;
    end else if (cnt_r != 7'd0) begin
      cnt_r <= cnt_r - 7'd1;
    end
    if (start) begin
      q_r <= num;
      d_r <= den;
      rem_r <= '0;
    end else if (cnt_r != 7'd0) begin
      if (!trial[64]) begin
        rem_r <= trial;
        q_r <= {q_r[62:0], 1'b1};
      end else begin
        rem_r <= {rem_r[63:0], q_r[63]};
        q_r <= {q_r[62:0], 1'b0};
      end
    end
  end

  assign done = (cnt_r == 7'd1);
  assign quo = trial[64] ? {q_r[62:0], 1'b0} : {q_r[62:0], 1'b1};
endmodule

// ----- rtl/core/ladrc_dp.sv -----
module ladrc_dp import ladrc_pkg::*; #(
  parameter int STATE_WIDTH = 48
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [31:0]         dt,
  input  logic signed [30:0]  b0,
  input  logic [19:0]         wc,
  input  logic [19:0]         wo,
  input  logic signed [31:0]  upper,
  input  logic signed [31:0]  lower,
  input  logic signed [31:0]  r_in,
  input  logic signed [31:0]  y_in,
  input  logic [30:0]         vdc_in,
  output logic signed [31:0]  drive,
  output logic signed [31:0]  z1_out,
  output logic signed [31:0]  z2_out
);
  localparam logic signed [63:0] SMAX = 64'sd1 <<< (STATE_WIDTH - 1);

  logic signed [63:0] z1_r, z2_r, ld_r, e_r, t_r, a_r, y_r, r_r;
  logic [30:0] v_r;
  op_t op_r;
  logic mstart, mdone, dstart, ddone, wait_r;
  logic [63:0] ma, mb, dn, dd, quo;
  logic [127:0] prod;
  logic mneg_r, big;
  logic signed [63:0] mres, dtres, sres, hi, lo, dyn, u;

  ladrc_mul u_mul (.clk, .rst_n, .start(mstart), .a(ma), .b(mb), .done(mdone), .prod);
  ladrc_div u_div (.clk, .rst_n, .start(dstart), .num(dn), .den(dd), .done(ddone), .quo);

  function automatic logic signed [63:0] sat_st(input logic signed [63:0] x);
    if (x > SMAX - 64'sd1) return SMAX - 64'sd1;
    if (x < -SMAX) return -SMAX;
    return x;
  endfunction

  // Operand selection for the shared multiplier; sign handled on magnitudes.
  always_comb begin
    ma = '0;
    mb = '0;
    mneg_r = 1'b0;
    unique case (cmd.op)
      OP_FF: begin
        ma = mag(64'(b0)); mb = mag(ld_r); mneg_r = b0[30] ^ ld_r[63];
      end
      OP_T1: begin
        ma = {43'd0, wo, 1'b0}; mb = mag(e_r); mneg_r = e_r[63];
      end
      OP_Z1, OP_Z2: begin
        ma = mag(t_r); mb = {32'd0, dt}; mneg_r = t_r[63];
      end
      OP_Q: begin
        ma = {44'd0, wo}; mb = {44'd0, wo};
      end
      OP_E2: begin
        ma = mag(a_r); mb = mag(e_r); mneg_r = a_r[63] ^ e_r[63];
      end
      OP_T2: begin
        ma = {44'd0, wc}; mb = mag(e_r); mneg_r = e_r[63];
      end
      OP_BOUND: begin
        ma = {33'd0, v_r}; mb = {32'd0, VBOUND_K};
      end
      default: ;
    endcase
  end

  assign mstart = cmd.start && (cmd.op != OP_LOAD) && (cmd.op != OP_ERR)
                  && (cmd.op != OP_DIV) && (cmd.op != OP_CLAMP) && (cmd.op != OP_NONE);
  assign dstart = cmd.start && (cmd.op == OP_DIV);
  assign dn = mag(t_r);
  assign dd = mag(64'(b0));

  reg mn_r;
  always_ff @(posedge clk) if (cmd.start) mn_r <= mneg_r;

  assign big = (prod[127:64] != 64'd0);
  assign mres = from_mag(mn_r, big ? {64{1'b1}} : prod[63:0]);
  assign dtres = from_mag(mn_r, prod[95:32]);
  assign sres = from_mag(t_r[63] ^ b0[30], quo);

  assign dyn = $signed({32'd0, prod[63:32]});
  always_comb begin
    hi = (dyn < 64'(upper)) ? dyn : 64'(upper);
    lo = (-dyn > 64'(lower)) ? -dyn : 64'(lower);
    u = a_r;
    if (u > hi) u = hi;
    if (u < lo) u = lo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z1_r <= '0;
      z2_r <= '0;
      ld_r <= '0;
      wait_r <= 1'b0;
      op_r <= OP_NONE;
    end else begin
      if (cmd.start) begin
        op_r <= cmd.op;
        wait_r <= mstart || dstart;
      end else if ((mdone || ddone) && wait_r) begin
        wait_r <= 1'b0;
      end
      if (cmd.start) begin
        unique case (cmd.op)
          OP_LOAD: begin
            r_r <= 64'(r_in); y_r <= 64'(y_in); v_r <= vdc_in;
            if (z1_r == 0 && z2_r == 0 && ld_r == 0) z1_r <= 64'(y_in);
          end
          OP_ERR: e_r <= sat_sub(z1_r, y_r);
          OP_CLAMP: ld_r <= u;
          default: ;
        endcase
      end else if (wait_r && (mdone || ddone)) begin
        unique case (op_r)
          OP_FF: t_r <= sat_add(z2_r, mres);
          OP_T1: t_r <= sat_sub(t_r, mres);
          OP_Z1: z1_r <= sat_st(sat_add(z1_r, dtres));
          OP_Q: a_r <= mres;
          OP_E2: t_r <= (mres == S64_MIN) ? S64_MAX : -mres;
          OP_Z2: begin
            z2_r <= sat_st(sat_add(z2_r, dtres));
            e_r <= sat_sub(r_r, z1_r);
          end
          OP_T2: t_r <= sat_sub(mres, z2_r);
          OP_DIV: a_r <= sres;
          default: ;
        endcase
      end
    end
  end

  assign sts.busy = wait_r;
  assign drive = ld_r[31:0];
  assign z1_out = sat32(z1_r);
  assign z2_out = sat32(z2_r);
endmodule

// ----- rtl/core/ladrc_ctrl.sv -----
module ladrc_ctrl import ladrc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd,
  input  sts_t sts
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN = 2'd1;
  localparam logic [1:0] S_OUT = 2'd2;

  logic [1:0] state_r, state_nxt;
  op_t op_r, op_nxt;
  logic go_r, go_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    go_nxt = 1'b0;
    cmd.start = 1'b0;
    cmd.op = op_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          cmd.op = OP_LOAD;
          op_nxt = OP_ERR;
          go_nxt = 1'b1;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (go_r) begin
          cmd.start = 1'b1;
        end else if (!sts.busy) begin
          if (op_r == OP_CLAMP) begin
            state_nxt = S_OUT;
          end else begin
            op_nxt = op_t'(op_r + 4'd1);
            go_nxt = 1'b1;
          end
        end
        if (go_r && (op_r == OP_ERR || op_r == OP_CLAMP)) begin
          // Register-only steps finish at once.
          if (op_r == OP_CLAMP) state_nxt = S_OUT;
          else begin
            op_nxt = OP_FF;
            go_nxt = 1'b1;
          end
        end
      end
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r <= OP_NONE;
      go_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r <= op_nxt;
      go_r <= go_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  a_out_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_RUN)) else $error("result without run");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> in_stall) else $error("accept while busy");
  a_start_idle_dp: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start && state_r == S_RUN) |-> !sts.busy) else $error("start while busy");
endmodule

// ----- rtl/core/ladrc_current_regulator_core.sv -----
// Channel  | Direction | Handshake            | Payload
// in_      | input     | in_valid / in_stall  | setpoint, measurement, link_voltage
// out_     | output    | out_valid/ out_stall | drive, tracked_output, disturbance
// cfg_     | APB       | psel/penable/pready  | six registers at 4*i
// An item runs in steps from one acceptance to the next: eight
// products on one shared 32x32 unit and a restoring divide set the pace,
// plus load, error, clamp and output steps.
// One item is in work at a time; the result is held until out_stall is low.
// Reset (synchronous, rst_n low) clears the observer state and loads defaults.
module ladrc_current_regulator_core import ladrc_pkg::*; #(
  parameter int STATE_WIDTH = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_setpoint,
  input  logic signed [31:0] in_measurement,
  input  logic [30:0]        in_link_voltage,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_drive,
  output logic signed [31:0] out_tracked_output,
  output logic signed [31:0] out_disturbance,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  logic [31:0] step_r;
  logic signed [30:0] gain_r;
  logic [19:0] wc_r, wo_r;
  logic signed [31:0] up_r, lo_r;
  cmd_t cmd;
  sts_t sts;
  logic [2:0] ridx;

  assign ridx = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= DEF_STEP;
      gain_r <= DEF_GAIN;
      wc_r <= DEF_WC;
      wo_r <= DEF_WO;
      up_r <= 32'sh7fffffff;
      lo_r <= 32'sh80000000;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'd0) begin
      unique case (ridx)
        REG_STEP: step_r <= cfg_pwdata;
        REG_GAIN: gain_r <= cfg_pwdata[30:0];
        REG_WC: wc_r <= cfg_pwdata[19:0];
        REG_WO: wo_r <= cfg_pwdata[19:0];
        REG_UPPER: up_r <= cfg_pwdata;
        REG_LOWER: lo_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_STEP: cfg_prdata = step_r;
      REG_GAIN: cfg_prdata = {{1{gain_r[30]}}, gain_r};
      REG_WC: cfg_prdata = {12'd0, wc_r};
      REG_WO: cfg_prdata = {12'd0, wo_r};
      REG_UPPER: cfg_prdata = up_r;
      REG_LOWER: cfg_prdata = lo_r;
      default: cfg_prdata = '0;
    endcase
  end

  ladrc_ctrl u_ctrl (.clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .cmd, .sts);

  ladrc_dp #(.STATE_WIDTH(STATE_WIDTH)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .dt(step_r == 32'd0 ? DEF_STEP : step_r),
    .b0(gain_r == 31'sd0 ? DEF_GAIN : gain_r),
    .wc(wc_r == 20'd0 ? DEF_WC : wc_r),
    .wo(wo_r == 20'd0 ? DEF_WO : wo_r),
    .upper(up_r), .lower(lo_r),
    .r_in(in_setpoint), .y_in(in_measurement), .vdc_in(in_link_voltage),
    .drive(out_drive), .z1_out(out_tracked_output), .z2_out(out_disturbance));
endmodule

// ----- verif/ladrc_current_regulator_core_test.sv -----
`timescale 1ns / 100ps

module ladrc_current_regulator_core_test;
  import ladrc_pkg::*;

  localparam int CYCLE_LIMIT = 5000000;
  localparam logic signed [63:0] I64_MAX = 64'sh7fffffffffffffff;
  localparam logic signed [63:0] I64_MIN = 64'sh8000000000000000;
  localparam logic signed [63:0] ST_MAX = 64'sd140737488355327;
  localparam logic signed [63:0] ST_MIN = -64'sd140737488355328;
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic signed [31:0] setpoint;
    logic signed [31:0] measurement;
    logic [30:0] link_voltage;
  } tick_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic signed [31:0] tracked;
    logic signed [31:0] disturb;
  } command_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_setpoint = '0;
  logic signed [31:0] in_measurement = '0;
  logic [30:0] in_link_voltage = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_drive, out_tracked_output, out_disturbance;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  ladrc_current_regulator_core dut (.*);

  // Mirror of the register file and the observer state.
  logic [31:0] m_step;
  logic signed [63:0] m_gain, m_upper, m_lower;
  logic [19:0] m_wc, m_wo;
  logic signed [63:0] z1_est, z2_est, prev_drive;

  tick_t pending_ticks[$];
  command_t expected_cmds[$];
  int errors = 0;
  int results_seen = 0;
  bit hold_in = 1'b0;
  int cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic signed [63:0] add_s(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? I64_MIN : I64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sub_s(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? I64_MIN : I64_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] abs_u(logic signed [63:0] a);
    logic [63:0] r;
    r = a;
    return a[63] ? ~r + 64'd1 : r;
  endfunction

  function automatic logic signed [63:0] signed_of(logic neg, logic [63:0] m);
    if (m[63]) return neg ? I64_MIN : I64_MAX;
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] mul_s(logic signed [63:0] a, logic signed [63:0] b);
    logic [127:0] p;
    logic neg;
    neg = a[63] != b[63];
    p = {64'd0, abs_u(a)} * {64'd0, abs_u(b)};
    if (p[127:64] != 0) return neg ? I64_MIN : I64_MAX;
    return signed_of(neg, p[63:0]);
  endfunction

  // Scaling by the step time works on the magnitude and truncates toward zero.
  function automatic logic signed [63:0] scale_dt(logic signed [63:0] s, logic [31:0] dt);
    logic [95:0] p;
    p = {32'd0, abs_u(s)} * {64'd0, dt};
    return signed_of(s[63], p[95:32]);
  endfunction

  function automatic logic signed [63:0] clip_state(logic signed [63:0] x);
    if (x > ST_MAX) return ST_MAX;
    if (x < ST_MIN) return ST_MIN;
    return x;
  endfunction

  function automatic logic signed [31:0] clip32(logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic command_t regulate(tick_t tk);
    logic [31:0] dt;
    logic signed [63:0] b0, wc, wo, r, y, z1, z2, e, t, u, dyn, hi, lo, neg_q;
    logic [63:0] pv;
    command_t c;
    dt = (m_step != 0) ? m_step : DEF_STEP;
    b0 = (m_gain != 0) ? m_gain : 64'sd10000;
    wc = (m_wc != 0) ? {44'd0, m_wc} : {44'd0, DEF_WC};
    wo = (m_wo != 0) ? {44'd0, m_wo} : {44'd0, DEF_WO};
    r = tk.setpoint;
    y = tk.measurement;
    z1 = z1_est;
    z2 = z2_est;
    // Cold start: align the output estimate to the first measurement.
    if (z1 == 0 && z2 == 0 && prev_drive == 0) z1 = y;
    e = sub_s(z1, y);
    t = add_s(z2, b0 * prev_drive);
    t = sub_s(t, mul_s(2 * wo, e));
    neg_q = mul_s(wo * wo, e);
    neg_q = (neg_q == I64_MIN) ? I64_MAX : -neg_q;
    z1_est = clip_state(add_s(z1, scale_dt(t, dt)));
    z2_est = clip_state(add_s(z2, scale_dt(neg_q, dt)));
    t = sub_s(mul_s(wc, sub_s(r, z1_est)), z2_est);
    u = signed_of(t[63] != b0[63], abs_u(t) / abs_u(b0));
    pv = {33'd0, tk.link_voltage} * {32'd0, VBOUND_K};
    dyn = $signed({32'd0, pv[63:32]});
    hi = (dyn < m_upper) ? dyn : m_upper;
    lo = (-dyn > m_lower) ? -dyn : m_lower;
    // The lower clamp comes last, so it wins when the limits cross.
    if (u > hi) u = hi;
    if (u < lo) u = lo;
    prev_drive = u;
    c.drive = u[31:0];
    c.tracked = clip32(z1_est);
    c.disturb = clip32(z2_est);
    return c;
  endfunction

  // Driver: bursts of items separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    logic go;
    logic took;
    tick_t tk;
    go = 1'b0;
    took = in_valid && !in_stall;
    if (rst_n) begin
      if (took) begin
        expected_cmds.push_back(regulate(pending_ticks[0]));
        void'(pending_ticks.pop_front());
      end
      if (!in_valid || took) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_ticks.size() != 0 && !hold_in) begin
          go = 1'b1;
          tk = pending_ticks[0];
          in_setpoint <= tk.setpoint;
          in_measurement <= tk.measurement;
          in_link_voltage <= tk.link_voltage;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
          end else begin
            burst_left--;
          end
        end
        in_valid <= go;
      end
    end
  end

  // Monitor and receiver stall pattern.
  int seg_left = 0;
  int seg_mode = 0;
  int long_left = 0;
  bit long_done = 1'b0;
  always @(posedge clk) begin
    command_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_cmds.size() == 0) begin
          $display("%0t: result with nothing expected: drive %h", $time, out_drive);
          errors++;
        end else begin
          want = expected_cmds.pop_front();
          if (out_drive !== want.drive) begin
            $display("%0t: drive expected %h actual %h", $time, want.drive, out_drive);
            errors++;
          end
          if (out_tracked_output !== want.tracked) begin
            $display("%0t: tracked_output expected %h actual %h", $time, want.tracked,
                     out_tracked_output);
            errors++;
          end
          if (out_disturbance !== want.disturb) begin
            $display("%0t: disturbance expected %h actual %h", $time, want.disturb,
                     out_disturbance);
            errors++;
          end
        end
      end
      if (long_left != 0) begin
        long_left--;
        out_stall <= 1'b1;
      end else if (!long_done && results_seen == 150) begin
        // One long hold-off so that the block backs up and stalls its input.
        long_done = 1'b1;
        long_left = 900;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(1, 200);
          seg_mode = $urandom_range(0, 3);
        end else begin
          seg_left--;
        end
        case (seg_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= $urandom_range(0, 1);
          2: out_stall <= ($urandom_range(0, 7) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_STEP: m_step = v;
      REG_GAIN: m_gain = {{33{v[30]}}, v[30:0]};
      REG_WC: m_wc = v[19:0];
      REG_WO: m_wo = v[19:0];
      REG_UPPER: m_upper = $signed(v);
      REG_LOWER: m_lower = $signed(v);
      default: ;
    endcase
  endtask

  task automatic write_all(logic [31:0] st, logic [31:0] g, logic [31:0] wc, logic [31:0] wo,
                           logic [31:0] up, logic [31:0] lw);
    write_reg(REG_STEP, st);
    write_reg(REG_GAIN, g);
    write_reg(REG_WC, wc);
    write_reg(REG_WO, wo);
    write_reg(REG_UPPER, up);
    write_reg(REG_LOWER, lw);
  endtask

  task automatic drain();
    while (pending_ticks.size() != 0 || expected_cmds.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic push_tick(logic [31:0] sp, logic [31:0] ms, logic [30:0] vd);
    tick_t tk;
    tk.setpoint = sp;
    tk.measurement = ms;
    tk.link_voltage = vd;
    pending_ticks.push_back(tk);
  endtask

  // Mostly plausible operating points with random content, some raw noise.
  task automatic push_random(int n);
    logic signed [31:0] sp;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        sp = $signed($urandom_range(0, 32'h0028_0000)) - 32'sh0014_0000;
        push_tick(sp, sp + $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000,
                  31'($urandom_range(32'h0064_0000, 32'h0320_0000)));
      end else if ($urandom_range(0, 4) == 0) begin
        push_tick($urandom, $urandom, ($urandom_range(0, 1) != 0) ? 31'h7fffffff : 31'd0);
      end else begin
        push_tick($urandom, $urandom, 31'($urandom));
      end
    end
  endtask

  initial begin
    m_step = DEF_STEP;
    m_gain = 64'sd10000;
    m_wc = DEF_WC;
    m_wo = DEF_WO;
    m_upper = 64'sd2147483647;
    m_lower = -64'sd2147483648;
    z1_est = 0;
    z2_est = 0;
    prev_drive = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: cold start, field extremes, zero and full link voltage.
    push_tick(32'sh0001_0000, 32'sh0000_8000, 31'h0190_0000);
    push_tick(32'sh0001_0000, 32'sh0000_c000, 31'h0190_0000);
    push_tick(32'sh7fffffff, 32'sh0, 31'h7fffffff);
    push_tick(32'sh80000000, 32'sh0, 31'h7fffffff);
    push_tick(32'sh0, 32'sh7fffffff, 31'h0190_0000);
    push_tick(32'sh0, 32'sh80000000, 31'h0190_0000);
    push_tick(32'sh7fffffff, 32'sh80000000, 31'd0);
    push_tick(32'sh80000000, 32'sh7fffffff, 31'h7fffffff);
    push_tick(32'sh0, 32'sh0, 31'd0);
    push_tick(32'shffffffff, 32'sh00000001, 31'd1);
    drain();

    // All zero settings fall back to the defaults.
    write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'h7fffffff, 32'h80000000);
    push_tick(32'sh0002_0000, 32'sh0001_0000, 31'h0100_0000);
    push_tick(32'sh0002_0000, 32'sh0001_8000, 31'h0100_0000);
    push_random(240);
    // Sender pauses halfway until every expected result has come.
    while (pending_ticks.size() > 120) @(posedge clk);
    hold_in = 1'b1;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    hold_in = 1'b0;
    drain();

    write_all(32'hffffffff, 32'(-1000000000), 32'd1000000, 32'd1000000,
              32'h0005_0000, 32'hfffb_0000);
    push_random(240);
    drain();

    // Crossed limits: the lower one wins.
    write_all(32'd1, 32'd1000000000, 32'd1, 32'd1, 32'h80000000, 32'h7fffffff);
    push_tick(32'sh0, 32'sh0, 31'h0100_0000);
    push_random(200);
    drain();

    write_all(32'd429497, 32'hffffffff, 32'd3000, 32'd9000, 32'h0014_0000, 32'hffd8_0000);
    push_random(240);
    drain();

    for (int k = 0; k < 3; k++) begin
      write_all($urandom, 32'($signed($urandom_range(0, 2000000000)) - 1000000000),
                $urandom_range(0, 1000000), $urandom_range(0, 1000000), $urandom, $urandom);
      push_random(180);
      drain();
    end

    // Writes beyond the register file are ignored.
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, $urandom);
    write_all(DEF_STEP, 32'd10000, 32'd800, 32'd2400, 32'h7fffffff, 32'h80000000);
    push_random(240);
    drain();

    if (errors == 0 && expected_cmds.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
